/* hdl/ymd_pkg.sv */
// ----------------------------------------------------------------------------
// ymd_pkg
// shared types and codes for the ymodem packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package ymd_pkg;

    localparam int unsigned TICK_W  = 24;
    localparam int unsigned INDEX_W = 10;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_EOT     = 3'd1;
    localparam status_t ST_CAN     = 3'd2;
    localparam status_t ST_TIMEOUT = 3'd3;
    localparam status_t ST_BAD     = 3'd4;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_CAN = 8'h18;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [INDEX_W-1:0] LAST_SHORT = 10'd127;
    localparam logic [INDEX_W-1:0] LAST_LONG  = 10'd1023;

    localparam logic [TICK_W-1:0] TICK_MAX      = 24'hFFFFFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 24'd1000;

    typedef struct packed {
        logic               kind;
        logic [7:0]         payload_byte;
        logic [INDEX_W-1:0] byte_index;
        status_t            packet_status;
        logic [7:0]         sequence_number;
        logic               long_packet;
    } result_t;

endpackage

`default_nettype wire

/* hdl/ymodem_packet_deframer_core.sv */
// ----------------------------------------------------------------------------
// ymodem_packet_deframer_core
// ymodem packet receiver front end with crc-16/xmodem check
// ----------------------------------------------------------------------------
// input beats carry either a received byte (s_tuser = 0) or one timer tick
// (s_tuser = 1). the block hunts for SOH or STX, collects sequence, its
// complement, 128 or 1024 payload bytes and a big-endian crc, and emits one
// output beat per payload byte plus one status beat per packet end. EOT and
// CAN while hunting, a tick timeout, and the final crc/complement check each
// give a status beat (m_tuser = 1).
// one input beat is taken every cycle while s_tready is high; a resulting
// output beat goes to the result register (or the skid entry) for the m_ side.
// the framing state updates in the same cycle the beat is accepted.
// a result register plus one skid entry decouple the sides: s_tready drops
// only while the skid entry is held, i.e. after the receiver stalls with
// a result pending and another result arrives.
// reset (aresetn low, synchronous) returns to hunting, empties the output
// and sets the timeout limit to 1000 ticks. cfg writes are always ready and
// should only be issued while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ymodem_packet_deframer_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [23:0] cfg_data,   // timeout_ticks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // rx_byte
    input  wire logic        s_tuser,    // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // payload_byte, byte_index, packet_status,
                                         // sequence_number, long_packet, zero pad
    output logic             m_tuser     // result_kind
);
    import ymd_pkg::*;

    logic    res_valid;
    result_t res;
    result_t out_res;

    assign cfg_ready = 1'b1;

    ymd_deframe u_deframe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_data  (cfg_data),
        .evt_valid (s_tvalid & s_tready),
        .evt_tick  (s_tuser),
        .evt_byte  (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    ymd_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {2'b00, out_res.long_packet, out_res.sequence_number,
                      out_res.packet_status, out_res.byte_index, out_res.payload_byte};

endmodule

`default_nettype wire

/* hdl/ymd_deframe.sv */
// ----------------------------------------------------------------------------
// ymd_deframe
// packet framing state, crc-16 check and tick timeout, one event per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ymd_deframe (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [ymd_pkg::TICK_W-1:0] cfg_data,
    input  wire logic                       evt_valid,
    input  wire logic                       evt_tick,
    input  wire logic [7:0]                 evt_byte,
    output logic                            res_valid,
    output ymd_pkg::result_t                res
);
    import ymd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SEQ  = 3'd1,
        PH_SEQC = 3'd2,
        PH_DATA = 3'd3,
        PH_CRCH = 3'd4,
        PH_CRCL = 3'd5
    } phase_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    phase_t             phase_reg,   phase_next;
    logic [INDEX_W-1:0] count_reg,   count_next;
    logic               long_reg,    long_next;
    logic [7:0]         seq_reg,     seq_next;
    logic [7:0]         seqc_reg,    seqc_next;
    logic [15:0]        crc_reg,     crc_next;
    logic [7:0]         crch_reg,    crch_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic [TICK_W-1:0]  timeout_reg;

    logic [TICK_W-1:0]  elapsed_inc;
    logic [INDEX_W-1:0] last_index;
    logic               do_clear;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_reg <= cfg_data;
        end
    end

    always_comb begin
        elapsed_inc  = (elapsed_reg == TICK_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
        last_index   = long_reg ? LAST_LONG : LAST_SHORT;
        phase_next   = phase_reg;
        count_next   = count_reg;
        long_next    = long_reg;
        seq_next     = seq_reg;
        seqc_next    = seqc_reg;
        crc_next     = crc_reg;
        crch_next    = crch_reg;
        elapsed_next = elapsed_reg;
        do_clear     = 1'b0;
        res_valid    = 1'b0;
        res.kind            = 1'b0;
        res.payload_byte    = 8'h00;
        res.byte_index      = '0;
        res.packet_status   = ST_OK;
        res.sequence_number = seq_reg;
        res.long_packet     = long_reg;

        if (evt_valid) begin
            if (evt_tick) begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc > timeout_reg) begin
                    res_valid         = 1'b1;
                    res.kind          = 1'b1;
                    res.packet_status = ST_TIMEOUT;
                    do_clear          = 1'b1;
                end
            end else begin
                case (phase_reg)
                    PH_HUNT: begin
                        if (evt_byte == CH_SOH || evt_byte == CH_STX) begin
                            long_next    = (evt_byte == CH_STX);
                            seq_next     = 8'h00;
                            seqc_next    = 8'h00;
                            count_next   = '0;
                            crc_next     = 16'h0000;
                            elapsed_next = '0;
                            phase_next   = PH_SEQ;
                        end else if (evt_byte == CH_EOT) begin
                            res_valid         = 1'b1;
                            res.kind          = 1'b1;
                            res.packet_status = ST_EOT;
                            do_clear          = 1'b1;
                        end else if (evt_byte == CH_CAN) begin
                            res_valid         = 1'b1;
                            res.kind          = 1'b1;
                            res.packet_status = ST_CAN;
                            do_clear          = 1'b1;
                        end
                    end
                    PH_SEQ: begin
                        seq_next     = evt_byte;
                        elapsed_next = '0;
                        phase_next   = PH_SEQC;
                    end
                    PH_SEQC: begin
                        seqc_next    = evt_byte;
                        elapsed_next = '0;
                        phase_next   = PH_DATA;
                    end
                    PH_DATA: begin
                        res_valid        = 1'b1;
                        res.payload_byte = evt_byte;
                        res.byte_index   = count_reg;
                        crc_next         = crc_byte(crc_reg, evt_byte);
                        elapsed_next     = '0;
                        if (count_reg >= last_index) begin
                            count_next = '0;
                            phase_next = PH_CRCH;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    PH_CRCH: begin
                        crch_next    = evt_byte;
                        elapsed_next = '0;
                        phase_next   = PH_CRCL;
                    end
                    PH_CRCL: begin
                        res_valid = 1'b1;
                        res.kind  = 1'b1;
                        if (seq_reg == ~seqc_reg && {crch_reg, evt_byte} == crc_reg) begin
                            res.packet_status = ST_OK;
                        end else begin
                            res.packet_status = ST_BAD;
                        end
                        do_clear = 1'b1;
                    end
                    default: begin
                        do_clear = 1'b1;
                    end
                endcase
            end
        end

        if (do_clear) begin
            phase_next   = PH_HUNT;
            count_next   = '0;
            long_next    = 1'b0;
            seq_next     = 8'h00;
            seqc_next    = 8'h00;
            crc_next     = 16'h0000;
            crch_next    = 8'h00;
            elapsed_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            count_reg   <= '0;
            long_reg    <= 1'b0;
            seq_reg     <= 8'h00;
            seqc_reg    <= 8'h00;
            crc_reg     <= 16'h0000;
            crch_reg    <= 8'h00;
            elapsed_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            long_reg    <= long_next;
            seq_reg     <= seq_next;
            seqc_reg    <= seqc_next;
            crc_reg     <= crc_next;
            crch_reg    <= crch_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/ymd_out_stage.sv */
// ----------------------------------------------------------------------------
// ymd_out_stage
// result register with a skid entry between the deframer and the output port
// ----------------------------------------------------------------------------
`default_nettype none

module ymd_out_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire ymd_pkg::result_t  in_data,
    output logic                   in_ready,
    output logic                   out_valid,
    output ymd_pkg::result_t       out_data,
    input  wire logic              out_ready
);
    import ymd_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = out_valid_reg & out_ready;
    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= in_data;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ymodem packet deframer core
// ----------------------------------------------------------------------------
// a queue of rx events (bytes and timer ticks) feeds a clocked stream driver;
// every accepted beat goes through a local model of the deframer, which
// queues the expected output beats. a clocked monitor compares each output
// beat field by field with the oldest expected one. a short directed part
// covers noise, EOT, CAN and timeouts while hunting, after the sequence and inside
// a long payload; random phases follow with well-formed short packets, corrupted
// sequence complements and crcs, truncated short and long packets, noise and tick
// bursts, across several timeout limits and with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ymd_pkg::*;

    typedef enum logic [2:0] {
        FR_HUNT,
        FR_SEQ,
        FR_SEQ_INV,
        FR_DATA,
        FR_CRC_HI,
        FR_CRC_LO
    } frame_phase_t;

    typedef struct packed {
        logic       tick;
        logic [7:0] rx;
    } rx_event_t;

    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_TICK     = 1'b1;
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam int FLAW_NONE = 0;
    localparam int FLAW_SEQ  = 1;
    localparam int FLAW_CRC  = 2;

    localparam int FULL_PACKET   = 4096;
    localparam int RANDOM_BUDGET = 150;
    localparam int N_PHASES      = 6;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [23:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    // deframer model state
    frame_phase_t       fr_phase;
    logic [INDEX_W-1:0] fr_count;
    logic               fr_long;
    logic [7:0]         fr_seq;
    logic [7:0]         fr_seq_inv;
    logic [7:0]         fr_crc_hi;
    logic [15:0]        fr_crc;
    logic [TICK_W-1:0]  fr_ticks;
    logic [TICK_W-1:0]  timeout_limit;

    rx_event_t rx_q[$];
    result_t   expected_beats[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int n_queued       = 0;
    int n_accepted     = 0;
    int n_results      = 0;
    int n_errors       = 0;
    int status_tally[5] = '{0, 0, 0, 0, 0};

    logic [TICK_W-1:0] phase_limit [N_PHASES] =
        '{24'hFFFFFF, 24'd5, 24'd2, 24'd40, 24'd0, 24'd1000};
    int phase_send_idle  [N_PHASES] = '{0, 67, 0, 15, 0, 15};
    int phase_recv_stall [N_PHASES] = '{0, 0, 67, 15, 0, 15};

    result_t beat_got;
    result_t beat_want;

    ymodem_packet_deframer_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic logic [15:0] crc16_xmodem_next(input logic [15:0] crc,
                                                      input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    task automatic clear_frame();
        fr_phase   = FR_HUNT;
        fr_count   = '0;
        fr_long    = 1'b0;
        fr_seq     = '0;
        fr_seq_inv = '0;
        fr_crc_hi  = '0;
        fr_crc     = '0;
        fr_ticks   = '0;
    endtask

    task automatic close_packet(input status_t st);
        result_t r;
        r = '0;
        r.kind            = KIND_STATUS;
        r.packet_status   = st;
        r.sequence_number = fr_seq;
        r.long_packet     = fr_long;
        expected_beats.push_back(r);
        status_tally[st]++;
        clear_frame();
    endtask

    task automatic deframe_event(input logic tick, input logic [7:0] b);
        result_t r;
        if (tick == OP_TICK) begin
            if (fr_ticks != TICK_MAX) fr_ticks++;
            if (fr_ticks > timeout_limit) close_packet(ST_TIMEOUT);
        end else begin
            case (fr_phase)
                FR_HUNT: begin
                    if (b == CH_SOH || b == CH_STX) begin
                        clear_frame();
                        fr_long  = (b == CH_STX);
                        fr_phase = FR_SEQ;
                    end else if (b == CH_EOT) begin
                        close_packet(ST_EOT);
                    end else if (b == CH_CAN) begin
                        close_packet(ST_CAN);
                    end
                end
                FR_SEQ: begin
                    fr_seq   = b;
                    fr_ticks = '0;
                    fr_phase = FR_SEQ_INV;
                end
                FR_SEQ_INV: begin
                    fr_seq_inv = b;
                    fr_ticks   = '0;
                    fr_phase   = FR_DATA;
                end
                FR_DATA: begin
                    r = '0;
                    r.kind            = KIND_DATA;
                    r.payload_byte    = b;
                    r.byte_index      = fr_count;
                    r.sequence_number = fr_seq;
                    r.long_packet     = fr_long;
                    expected_beats.push_back(r);
                    fr_crc   = crc16_xmodem_next(fr_crc, b);
                    fr_ticks = '0;
                    if (fr_count == (fr_long ? LAST_LONG : LAST_SHORT)) begin
                        fr_count = '0;
                        fr_phase = FR_CRC_HI;
                    end else begin
                        fr_count++;
                    end
                end
                FR_CRC_HI: begin
                    fr_crc_hi = b;
                    fr_ticks  = '0;
                    fr_phase  = FR_CRC_LO;
                end
                FR_CRC_LO: begin
                    if ({fr_crc_hi, b} == fr_crc && fr_seq == ~fr_seq_inv)
                        close_packet(ST_OK);
                    else
                        close_packet(ST_BAD);
                end
                default: clear_frame();
            endcase
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_q.push_back({OP_BYTE, b});
        n_queued++;
    endtask

    task automatic push_tick();
        rx_q.push_back({OP_TICK, 8'h00});
        n_queued++;
    endtask

    // header, then cut bytes of seq, complement, payload and crc
    task automatic queue_packet(input logic is_long, input int flaw, input int cut);
        logic [7:0]  body[$];
        logic [7:0]  seq;
        logic [15:0] crc;
        int          n_pay;
        int          pace;
        seq   = 8'($urandom_range(0, 255));
        crc   = '0;
        n_pay = is_long ? 1024 : 128;
        pace  = (timeout_limit < 4) ? int'(timeout_limit) : 4;
        body.push_back(seq);
        if (flaw == FLAW_SEQ)
            body.push_back(~seq ^ (8'h01 << $urandom_range(0, 7)));
        else
            body.push_back(~seq);
        for (int i = 0; i < n_pay; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
            crc = crc16_xmodem_next(crc, body[body.size() - 1]);
        end
        if (flaw == FLAW_CRC) crc ^= 16'h0001 << $urandom_range(0, 15);
        body.push_back(crc[15:8]);
        body.push_back(crc[7:0]);
        push_byte(is_long ? CH_STX : CH_SOH);
        for (int i = 0; i < body.size() && i < cut; i++) begin
            // ticks between bytes stay within the limit
            if ($urandom_range(0, 19) == 0) repeat ($urandom_range(0, pace)) push_tick();
            push_byte(body[i]);
        end
    endtask

    task automatic queue_random_traffic(input int budget);
        int start;
        int pick;
        int flaw;
        int cut;
        int burst;
        logic [7:0] b;
        start = n_queued;
        while (n_queued - start < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                flaw = $urandom_range(0, 9);
                flaw = (flaw < 8) ? FLAW_NONE : ((flaw == 8) ? FLAW_SEQ : FLAW_CRC);
                queue_packet(1'b0, flaw, FULL_PACKET);
            end else if (pick < 65 && timeout_limit <= 64) begin
                case ($urandom_range(0, 4))
                    0: cut = 0;
                    1: cut = 1;
                    2: cut = 2;
                    3: cut = 2 + $urandom_range(1, 127);
                    default: cut = 2 + 128 + 1;
                endcase
                queue_packet(1'($urandom_range(0, 1)), FLAW_NONE, cut);
                repeat (int'(timeout_limit) + 1) push_tick();
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 6)) begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_SOH || b == CH_STX) b ^= 8'h40;
                    push_byte(b);
                end
            end else if (pick < 85) begin
                push_byte($urandom_range(0, 1) ? CH_EOT : CH_CAN);
            end else if (pick < 95) begin
                burst = (timeout_limit < 40) ? int'(timeout_limit) : 40;
                repeat ($urandom_range(1, burst + 2)) push_tick();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1)) push_tick();
                    else push_byte(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    task automatic write_timeout(input logic [TICK_W-1:0] limit);
        cfg_valid <= 1'b1;
        cfg_data  <= limit;
        do @(posedge aclk); while (!cfg_ready);
        timeout_limit = limit;
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        while ((rx_q.size() != 0 || s_tvalid || expected_beats.size() != 0)
               && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_beats.size() != 0) begin
            if (n_errors < MAX_REPORTS)
                $display("missing: %0d expected beats never arrived", expected_beats.size());
            n_errors += expected_beats.size();
            expected_beats.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // source driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                deframe_event(s_tuser, s_tdata);
                rx_q.delete(0);
                n_accepted++;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (rx_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= rx_q[0].tick;
                    s_tdata  <= rx_q[0].rx;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // sink monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                beat_got.kind            = m_tuser;
                beat_got.payload_byte    = m_tdata[7:0];
                beat_got.byte_index      = m_tdata[17:8];
                beat_got.packet_status   = m_tdata[20:18];
                beat_got.sequence_number = m_tdata[28:21];
                beat_got.long_packet     = m_tdata[29];
                if (expected_beats.size() == 0) begin
                    if (n_errors < MAX_REPORTS)
                        $display("unexpected beat: kind %0d tdata %08h", m_tuser, m_tdata);
                    n_errors++;
                end else begin
                    beat_want = expected_beats.pop_front();
                    if (beat_got !== beat_want) begin
                        if (n_errors < MAX_REPORTS) begin
                            $display({"mismatch exp: kind %0d byte %02h index %0d",
                                      " status %0d seq %02h long %0d"},
                                     beat_want.kind, beat_want.payload_byte,
                                     beat_want.byte_index, beat_want.packet_status,
                                     beat_want.sequence_number, beat_want.long_packet);
                            $display({"         got: kind %0d byte %02h index %0d",
                                      " status %0d seq %02h long %0d"},
                                     beat_got.kind, beat_got.payload_byte,
                                     beat_got.byte_index, beat_got.packet_status,
                                     beat_got.sequence_number, beat_got.long_packet);
                        end
                        n_errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        clear_frame();
        timeout_limit = TIMEOUT_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // noise, EOT, CAN and ticks under the reset limit
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h03);
        push_byte(CH_EOT);
        push_byte(8'h80);
        push_byte(CH_CAN);
        push_tick();
        push_tick();
        push_byte(8'h7F);
        wait_idle();

        // zero limit: timeout while hunting, after the sequence, inside a long payload
        write_timeout('0);
        push_tick();
        push_byte(CH_SOH);
        push_byte(8'h33);
        push_tick();
        push_byte(CH_STX);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_byte(8'hFF);
        push_tick();
        push_byte(CH_EOT);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            write_timeout(phase_limit[p]);
            send_idle_pct  = phase_send_idle[p];
            recv_stall_pct = phase_recv_stall[p];
            queue_random_traffic(RANDOM_BUDGET);
        end
        wait_idle();

        $display("%0d input beats accepted, %0d output beats checked over %0d timeout settings",
                 n_accepted, n_results, N_PHASES + 2);
        $display("packet ends: ok %0d, bad %0d, eot %0d, cancel %0d, timeout %0d",
                 status_tally[ST_OK], status_tally[ST_BAD], status_tally[ST_EOT],
                 status_tally[ST_CAN], status_tally[ST_TIMEOUT]);
        if (n_errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #400000;
        $display("timeout: %0d of %0d input beats accepted, %0d beats outstanding",
                 n_accepted, n_queued, expected_beats.size());
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* ymodem_packet_deframer_core.f */
hdl/ymd_pkg.sv
hdl/ymd_deframe.sv
hdl/ymd_out_stage.sv
hdl/ymodem_packet_deframer_core.sv
sim/tb_top.sv
